FILE: hdl/cfs_pkg.sv
// cfs_pkg: shared types and constants for the CSV field splitter.
// No dependencies; imported by csv_field_splitter, its checker and its test.
`default_nettype none

package cfs_pkg;

  localparam int CHAR_BITS     = 16;
  localparam int MAX_DELIM_LEN = 4;
  localparam int WIN_DEPTH     = 4;
  localparam int RES_MAX       = WIN_DEPTH + 1;   // window decisions plus final mark
  localparam int OBUF_DEPTH    = 8;

  localparam int WIN_CNT_W  = $clog2(WIN_DEPTH + 1);
  localparam int WIN_IDX_W  = $clog2(WIN_DEPTH);
  localparam int XWIN_IDX_W = $clog2(2 * WIN_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_MAX + 1);
  localparam int RES_IDX_W  = $clog2(RES_MAX);
  localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + RES_MAX + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = CHAR_BITS;
  localparam int DLEN_W     = 3;

  localparam logic [CHAR_BITS-1:0] QUOTE_CHAR    = CHAR_BITS'(34);  // '"'
  localparam logic [CHAR_BITS-1:0] DEFAULT_DELIM = CHAR_BITS'(44);  // ','

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELIM_LEN   = 3'd0,
    REG_DELIM_CHAR0 = 3'd1,
    REG_DELIM_CHAR1 = 3'd2,
    REG_DELIM_CHAR2 = 3'd3,
    REG_DELIM_CHAR3 = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] ch;
    logic                 is_char;
    logic                 line_done;
    logic                 last;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/csv_field_splitter.sv
// csv_field_splitter: splits a CSV line, one character word per item, into fields.
// An accepted item is held in the input register, decoded and written into the output
// buffer. Throughput: one input word per cycle while in_stall is low; results leave
// one per cycle while out_stall is low, through an 8-entry output buffer.
// Reset (rst_n low, synchronous): window empty, outside quotes, delimiter is ","
// of length one, input register and output buffer empty.
`default_nettype none

module csv_field_splitter
  import cfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input channel
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [CHAR_BITS-1:0]  in_char,
  input  wire logic                  in_has_char,
  input  wire logic                  in_line_end,
  // result channel
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [CHAR_BITS-1:0]  out_char,
  output      logic                  out_is_char,
  output      logic                  out_line_done,
  output      logic                  out_last_of_item
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [DLEN_W-1:0]    delim_len_r;
  logic [CHAR_BITS-1:0] delim_char_r [0:MAX_DELIM_LEN-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_len_r <= DLEN_W'(1);
      for (int i = 0; i < MAX_DELIM_LEN; i++) begin
        delim_char_r[i] <= (i == 0) ? DEFAULT_DELIM : '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_idx))
        REG_DELIM_LEN:   delim_len_r     <= cfg_data[DLEN_W-1:0];
        REG_DELIM_CHAR0: delim_char_r[0] <= cfg_data[CHAR_BITS-1:0];
        REG_DELIM_CHAR1: delim_char_r[1] <= cfg_data[CHAR_BITS-1:0];
        REG_DELIM_CHAR2: delim_char_r[2] <= cfg_data[CHAR_BITS-1:0];
        REG_DELIM_CHAR3: delim_char_r[3] <= cfg_data[CHAR_BITS-1:0];
        default: ;  // indexes past the list are ignored
      endcase
    end
  end

  // Effective delimiter length: zero acts as one, large values saturate.
  logic [WIN_CNT_W-1:0] len_eff;
  always_comb begin
    if (delim_len_r == '0) begin
      len_eff = WIN_CNT_W'(1);
    end else if (32'(delim_len_r) > MAX_DELIM_LEN) begin
      len_eff = WIN_CNT_W'(MAX_DELIM_LEN);
    end else begin
      len_eff = WIN_CNT_W'(delim_len_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                 in_vld_r;
  logic [CHAR_BITS-1:0] in_char_r;
  logic                 in_has_r;
  logic                 in_end_r;
  logic                 commit;     // registered item is decoded into the buffer
  logic                 in_acc;

  assign in_stall = in_vld_r && !commit;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (commit) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_char_r <= in_char;
      in_has_r  <= in_has_char;
      in_end_r  <= in_line_end;
    end
  end

  // ---------------------------------------------------------------------------
  // Lookahead window state
  // Never more than WIN_DEPTH-1 characters stay pending after a decode, so the
  // push of a new character always has room.
  // ---------------------------------------------------------------------------
  logic [CHAR_BITS-1:0] win_r [0:WIN_DEPTH-1];
  logic [CHAR_BITS-1:0] win_nxt [0:WIN_DEPTH-1];
  logic [WIN_CNT_W-1:0] win_cnt_r, win_cnt_nxt;
  logic                 quoted_r, quoted_nxt;

  // ---------------------------------------------------------------------------
  // Single-pass decode: push, then up to WIN_DEPTH drain steps, then line end.
  // Each step consumes a quote pair, a lone quote, a full delimiter or one char.
  // ---------------------------------------------------------------------------
  res_t                 res [0:RES_MAX-1];
  logic [RES_CNT_W-1:0] res_n;

  always_comb begin
    logic [CHAR_BITS-1:0]  w [0:2*WIN_DEPTH-1];
    logic [WIN_CNT_W-1:0]  n;
    logic [WIN_CNT_W-1:0]  p;
    logic [WIN_CNT_W-1:0]  rem;
    logic [CHAR_BITS-1:0]  c;
    logic                  q;
    logic                  stop;
    logic                  match;

    for (int i = 0; i < 2 * WIN_DEPTH; i++) begin
      w[i] = (i < WIN_DEPTH) ? win_r[i] : '0;
    end
    if (in_has_r) begin
      w[XWIN_IDX_W'(win_cnt_r)] = in_char_r;
    end
    n     = win_cnt_r + WIN_CNT_W'(in_has_r);
    p     = '0;
    rem   = '0;
    c     = '0;
    q     = quoted_r;
    stop  = 1'b0;
    match = 1'b0;
    res_n = '0;
    for (int k = 0; k < RES_MAX; k++) begin
      res[k] = '0;
    end

    for (int s = 0; s < WIN_DEPTH; s++) begin
      if (!stop && (p < n)) begin
        c   = w[XWIN_IDX_W'(p)];
        rem = n - p;
        if (c == QUOTE_CHAR) begin
          if ((rem < WIN_CNT_W'(2)) && !in_end_r) begin
            stop = 1'b1;       // wait: could be the first of a quote pair
          end else if ((rem >= WIN_CNT_W'(2)) && (w[XWIN_IDX_W'(p + 1)] == QUOTE_CHAR)) begin
            res[res_n[RES_IDX_W-1:0]] = '{ch: QUOTE_CHAR, is_char: 1'b1,
                                           line_done: 1'b0, last: 1'b0};
            res_n = res_n + RES_CNT_W'(1);
            p     = p + WIN_CNT_W'(2);
          end else begin
            q = !q;
            p = p + WIN_CNT_W'(1);
          end
        end else if (!q) begin
          if ((rem < len_eff) && !in_end_r) begin
            stop = 1'b1;       // wait: not enough chars to rule out a delimiter
          end else begin
            match = (rem >= len_eff);
            for (int j = 0; j < MAX_DELIM_LEN; j++) begin
              if ((WIN_CNT_W'(j) < len_eff) && (w[XWIN_IDX_W'(p + j)] != delim_char_r[j])) begin
                match = 1'b0;
              end
            end
            if (match) begin
              res[res_n[RES_IDX_W-1:0]] = '{ch: '0, is_char: 1'b0,
                                             line_done: 1'b0, last: 1'b0};
              p = p + len_eff;
            end else begin
              res[res_n[RES_IDX_W-1:0]] = '{ch: c, is_char: 1'b1,
                                             line_done: 1'b0, last: 1'b0};
              p = p + WIN_CNT_W'(1);
            end
            res_n = res_n + RES_CNT_W'(1);
          end
        end else begin
          res[res_n[RES_IDX_W-1:0]] = '{ch: c, is_char: 1'b1,
                                         line_done: 1'b0, last: 1'b0};
          res_n = res_n + RES_CNT_W'(1);
          p     = p + WIN_CNT_W'(1);
        end
      end
    end

    for (int i = 0; i < WIN_DEPTH; i++) begin
      win_nxt[i] = w[XWIN_IDX_W'(p + i)];
    end
    win_cnt_nxt = n - p;
    quoted_nxt  = q;

    // line end: close the line with the final end-of-field mark
    if (in_end_r) begin
      win_cnt_nxt = '0;
      quoted_nxt  = 1'b0;
      res[res_n[RES_IDX_W-1:0]] = '{ch: '0, is_char: 1'b0,
                                     line_done: 1'b1, last: 1'b0};
      res_n = res_n + RES_CNT_W'(1);
    end

    if (res_n != '0) begin
      res[RES_IDX_W'(res_n - RES_CNT_W'(1))].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cnt_r <= '0;
      quoted_r  <= 1'b0;
    end else if (commit) begin
      win_cnt_r <= win_cnt_nxt;
      quoted_r  <= quoted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      for (int i = 0; i < WIN_DEPTH; i++) begin
        win_r[i] <= win_nxt[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output buffer: head at entry 0, shifts on pop, new results appended behind
  // whatever stays. An item commits only when all its results fit.
  // ---------------------------------------------------------------------------
  res_t                  obuf_r [0:OBUF_DEPTH-1];
  res_t                  obuf_nxt [0:OBUF_DEPTH-1];
  logic [OBUF_CNT_W-1:0] obuf_cnt_r, obuf_cnt_nxt;
  logic [OBUF_CNT_W-1:0] base;
  logic                  pop;

  assign out_valid        = (obuf_cnt_r != '0);
  assign pop              = out_valid && !out_stall;
  assign base             = obuf_cnt_r - OBUF_CNT_W'(pop);
  assign commit           = in_vld_r &&
                            ((base + OBUF_CNT_W'(res_n)) <= OBUF_CNT_W'(OBUF_DEPTH));
  assign obuf_cnt_nxt     = base + (commit ? OBUF_CNT_W'(res_n) : '0);

  assign out_char         = obuf_r[0].ch;
  assign out_is_char      = obuf_r[0].is_char;
  assign out_line_done    = obuf_r[0].line_done;
  assign out_last_of_item = obuf_r[0].last;

  always_comb begin
    logic [OBUF_CNT_W-1:0] off;
    off = '0;
    for (int i = 0; i < OBUF_DEPTH; i++) begin
      if (pop && (i < OBUF_DEPTH - 1)) begin
        obuf_nxt[i] = obuf_r[(i + 1) % OBUF_DEPTH];
      end else begin
        obuf_nxt[i] = obuf_r[i];
      end
      off = OBUF_CNT_W'(i) - base;
      if (commit && (OBUF_CNT_W'(i) >= base) && (off < OBUF_CNT_W'(res_n))) begin
        obuf_nxt[i] = res[off[RES_IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obuf_cnt_r <= '0;
    end else begin
      obuf_cnt_r <= obuf_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OBUF_DEPTH; i++) begin
      obuf_r[i] <= obuf_nxt[i];
    end
  end

endmodule

`default_nettype wire

FILE: verif/csv_field_splitter_checker.sv
// csv_field_splitter_checker: watches the config port and both word channels of
// csv_field_splitter, predicts every result word and compares in order.
// Depends on cfs_pkg for widths, register indexes and the result struct.
`default_nettype none

module csv_field_splitter_checker
  import cfs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire logic [CHAR_BITS-1:0]  in_char,
  input  wire logic                  in_has_char,
  input  wire logic                  in_line_end,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire logic [CHAR_BITS-1:0]  out_char,
  input  wire logic                  out_is_char,
  input  wire logic                  out_line_done,
  input  wire logic                  out_last_of_item,
  output int                         owed,
  output int                         mismatches
);

  logic [DLEN_W-1:0]    dlen;
  logic [CHAR_BITS-1:0] dch [MAX_DELIM_LEN];
  logic [CHAR_BITS-1:0] win [WIN_DEPTH];
  int                   win_cnt;
  bit                   quoted;
  res_t                 batch [$];
  res_t                 field_stream [$];
  int                   fails = 0;
  int                   printed = 0;

  assign mismatches = fails;

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    fails++;
    if (printed < 40) begin
      printed++;
      $display("%0t splitter mismatch on %s: want %0h got %0h", $time, what, want, got);
    end
  endtask

  function automatic int delim_span();
    if (dlen == 0) return 1;
    if (dlen > MAX_DELIM_LEN) return MAX_DELIM_LEN;
    return int'(dlen);
  endfunction

  task automatic put_result(input logic [CHAR_BITS-1:0] ch, input logic is_ch,
                            input logic done);
    res_t r;
    r.ch        = ch;
    r.is_char   = is_ch;
    r.line_done = done;
    r.last      = 1'b0;
    batch.push_back(r);
  endtask

  task automatic shift_window(input int k);
    if (k > win_cnt) k = win_cnt;
    for (int i = 0; i + k < win_cnt; i++) win[i] = win[i + k];
    win_cnt -= k;
  endtask

  // Decide pending characters; at_end means nothing follows on this line.
  task automatic settle_window(input bit at_end);
    int span;
    bit hit;
    span = delim_span();
    while (win_cnt > 0) begin
      if (win[0] == QUOTE_CHAR) begin
        if (win_cnt < 2 && !at_end) return;
        if (win_cnt >= 2 && win[1] == QUOTE_CHAR) begin
          put_result(QUOTE_CHAR, 1'b1, 1'b0);
          shift_window(2);
        end else begin
          quoted = !quoted;
          shift_window(1);
        end
      end else if (!quoted) begin
        if (win_cnt < span && !at_end) return;
        hit = (win_cnt >= span);
        if (hit) begin
          for (int j = 0; j < span; j++) if (win[j] != dch[j]) hit = 1'b0;
        end
        if (hit) begin
          put_result('0, 1'b0, 1'b0);
          shift_window(span);
        end else begin
          put_result(win[0], 1'b1, 1'b0);
          shift_window(1);
        end
      end else begin
        put_result(win[0], 1'b1, 1'b0);
        shift_window(1);
      end
    end
  endtask

  task automatic split_char(input logic [CHAR_BITS-1:0] ch, input logic has, input logic le);
    res_t r;
    batch.delete();
    if (has && win_cnt < WIN_DEPTH) begin
      win[win_cnt] = ch;
      win_cnt++;
    end
    settle_window(le);
    if (le) begin
      win_cnt = 0;
      put_result('0, 1'b0, 1'b1);
      quoted = 1'b0;
    end
    foreach (batch[i]) begin
      r = batch[i];
      r.last = (i == batch.size() - 1);
      field_stream.push_back(r);
    end
  endtask

  task automatic check_word();
    res_t want;
    if (field_stream.size() == 0) begin
      report("unowed word, char", '0, 32'(out_char));
      return;
    end
    want = field_stream.pop_front();
    if (out_char !== want.ch)
      report("char", 32'(want.ch), 32'(out_char));
    if (out_is_char !== want.is_char)
      report("is_char", 32'(want.is_char), 32'(out_is_char));
    if (out_line_done !== want.line_done)
      report("line_done", 32'(want.line_done), 32'(out_line_done));
    if (out_last_of_item !== want.last)
      report("last_of_item", 32'(want.last), 32'(out_last_of_item));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      dlen    = DLEN_W'(1);
      dch[0]  = DEFAULT_DELIM;
      dch[1]  = '0;
      dch[2]  = '0;
      dch[3]  = '0;
      win_cnt = 0;
      quoted  = 1'b0;
      field_stream.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_idx))
          REG_DELIM_LEN:   dlen   = cfg_data[DLEN_W-1:0];
          REG_DELIM_CHAR0: dch[0] = cfg_data;
          REG_DELIM_CHAR1: dch[1] = cfg_data;
          REG_DELIM_CHAR2: dch[2] = cfg_data;
          REG_DELIM_CHAR3: dch[3] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) split_char(in_char, in_has_char, in_line_end);
      if (out_valid && !out_stall) check_word();
    end
    owed = field_stream.size();
  end

endmodule

`default_nettype wire

FILE: verif/csv_field_splitter_test.sv
// csv_field_splitter_test: drives CSV lines word by word into csv_field_splitter,
// with directed corner cases first and then random lines under changing delimiters.
// Depends on cfs_pkg, csv_field_splitter and csv_field_splitter_checker.
`default_nettype none

module csv_field_splitter_test;
  import cfs_pkg::*;

  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, fills the output buffer
  localparam int STALL_LIMIT  = 4000;  // cycles with no word moving before we give up
  localparam int RANDOM_ITEMS = 360;
  localparam int PHASES       = 6;
  localparam int SETTLE       = 8;     // allow for words still in flight

  typedef enum int {FLOW, COIN, CHOKE, SPARSE} stall_mode_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CHAR_BITS-1:0]  in_char = '0;
  logic                  in_has_char = 1'b0;
  logic                  in_line_end = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CHAR_BITS-1:0]  out_char;
  logic                  out_is_char;
  logic                  out_line_done;
  logic                  out_last_of_item;

  int owed;
  int mismatches;
  int idle_cycles = 0;
  int burst_left = 0;
  bit squeeze = 1'b0;   // asks the receiver for its one long hold-off

  // Stimulus-side copy of the delimiter, only used to build lines that hit it.
  logic [CHAR_BITS-1:0] cur_delim [MAX_DELIM_LEN];
  int                   cur_span = 1;

  always #1 clk = ~clk;

  csv_field_splitter dut (.*);

  csv_field_splitter_checker checker_i (.*);

  // Watchdog: any accepted word on either channel resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Receiver: segments of random length, each with its own stall habit.
  // The long hold-off runs once, when the main sequence raises squeeze.
  initial begin : receiver
    stall_mode_t mode;
    int          seg;
    bit          held;
    held = 1'b0;
    @(posedge rst_n);
    forever begin
      if (squeeze && !held) begin
        held = 1'b1;
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end
      mode = stall_mode_t'($urandom_range(0, 3));
      seg  = $urandom_range(4, 40);
      repeat (seg) begin
        @(negedge clk);
        case (mode)
          FLOW:    out_stall <= 1'b0;
          COIN:    out_stall <= ($urandom_range(0, 1) == 1);
          CHOKE:   out_stall <= ($urandom_range(0, 9) < 8);
          default: out_stall <= ($urandom_range(0, 9) == 0);
        endcase
      end
    end
  end

  // One register write; cfg_we is lowered by the caller after a group of writes.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
  endtask

  // Writes all five delimiter registers. Upper bits of the length word are
  // don't-care for the block, so they carry whatever the caller passes.
  task automatic apply_delim(input logic [CFG_DATA_W-1:0] len_word,
                             input logic [CHAR_BITS-1:0] c0, input logic [CHAR_BITS-1:0] c1,
                             input logic [CHAR_BITS-1:0] c2, input logic [CHAR_BITS-1:0] c3,
                             input bit stray);
    int lv;
    write_reg(REG_DELIM_LEN, len_word);
    write_reg(REG_DELIM_CHAR0, c0);
    write_reg(REG_DELIM_CHAR1, c1);
    write_reg(REG_DELIM_CHAR2, c2);
    write_reg(REG_DELIM_CHAR3, c3);
    // an index past the last register must be ignored
    if (stray) begin
      write_reg(CFG_IDX_W'(REG_DELIM_CHAR3 + $urandom_range(1, 3)), CFG_DATA_W'($urandom));
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_delim[0] = c0;
    cur_delim[1] = c1;
    cur_delim[2] = c2;
    cur_delim[3] = c3;
    lv = int'(len_word[DLEN_W-1:0]);
    cur_span = (lv == 0) ? 1 : (lv > MAX_DELIM_LEN) ? MAX_DELIM_LEN : lv;
  endtask

  // Sender: words go out in bursts; between bursts valid may drop for a while.
  task automatic send_word(input logic [CHAR_BITS-1:0] ch, input logic has, input logic le);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_char     <= ch;
    in_has_char <= has;
    in_line_end <= le;
    do @(posedge clk); while (in_stall);
  endtask

  // Let the block run dry: every owed word out, then a SETTLE wait so
  // that words which produce nothing have cleared the pipeline too.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [CHAR_BITS-1:0] pick_punct();
    case ($urandom_range(0, 5))
      0:       return CHAR_BITS'(",");
      1:       return CHAR_BITS'(";");
      2:       return CHAR_BITS'("|");
      3:       return CHAR_BITS'(":");
      4:       return CHAR_BITS'("\t");
      default: return QUOTE_CHAR;
    endcase
  endfunction

  function automatic logic [CHAR_BITS-1:0] pick_delim_char();
    if ($urandom_range(0, 3) == 0) return CHAR_BITS'($urandom);
    return pick_punct();
  endfunction

  // A random line: quotes, whole delimiters, stray delimiter pieces, letters
  // and raw 16-bit noise. Closes either on its last char or on a bare end word.
  task automatic send_line(inout int sent);
    logic [CHAR_BITS-1:0] body [$];
    int                   pieces;
    int                   kind;
    bit                   bare;
    pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 8);
    for (int p = 0; p < pieces; p++) begin
      kind = $urandom_range(0, 9);
      if (kind < 2) body.push_back(QUOTE_CHAR);
      else if (kind < 4) begin
        for (int j = 0; j < cur_span; j++) body.push_back(cur_delim[j]);
      end
      else if (kind < 5) body.push_back(cur_delim[$urandom_range(0, cur_span - 1)]);
      else if (kind < 9) body.push_back(CHAR_BITS'($urandom_range(97, 122)));
      else body.push_back(CHAR_BITS'($urandom));
    end
    bare = (body.size() == 0) || ($urandom_range(0, 1) == 1);
    foreach (body[i]) begin
      // now and then a word with no char and no end, which the block ignores
      if ($urandom_range(0, 24) == 0) send_word(CHAR_BITS'($urandom), 1'b0, 1'b0);
      send_word(body[i], 1'b1, (i == body.size() - 1) && !bare);
      sent++;
    end
    if (bare) begin
      send_word(CHAR_BITS'($urandom), 1'b0, 1'b1);
      sent++;
    end
  endtask

  initial begin : main
    int sent;
    int lv;
    sent = 0;
    cur_delim[0] = DEFAULT_DELIM;
    cur_delim[1] = '0;
    cur_delim[2] = '0;
    cur_delim[3] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part, reset delimiter (comma, length one) ----
    send_word(16'hFFFF, 1'b0, 1'b0);              // no char, no end: nothing happens
    // a,",""",<FFFF> : comma inside quotes, doubled quote inside quotes
    send_word(CHAR_BITS'("a"), 1'b1, 1'b0);
    send_word(DEFAULT_DELIM, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(DEFAULT_DELIM, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(DEFAULT_DELIM, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b1);
    send_word('0, 1'b0, 1'b1);                    // empty line: one empty field
    // doubled quote outside quotes, zero char, then a lone quote at line end
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(16'h0000, 1'b1, 1'b0);
    send_word(QUOTE_CHAR, 1'b1, 1'b1);
    // quote never closed: line still ends normally
    send_word(QUOTE_CHAR, 1'b1, 1'b0);
    send_word(CHAR_BITS'("z"), 1'b1, 1'b1);
    quiesce();

    // length zero behaves as length one
    apply_delim('0, CHAR_BITS'(";"), '0, '0, '0, 1'b0);
    send_word(CHAR_BITS'("x"), 1'b1, 1'b0);
    send_word(CHAR_BITS'(";"), 1'b1, 1'b0);
    send_word('0, 1'b0, 1'b1);                    // end with no char flushes the window
    quiesce();

    // length 7 saturates to four; full match, then a partial one cut by line end
    apply_delim(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'h0000, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'h0000, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'h0000, 1'b1, 1'b1);
    quiesce();

    // delimiter changes while a char is still pending in the window
    apply_delim(CFG_DATA_W'(2), CHAR_BITS'(":"), CHAR_BITS'(":"), '0, '0, 1'b0);
    send_word(CHAR_BITS'("p"), 1'b1, 1'b0);
    send_word(CHAR_BITS'(":"), 1'b1, 1'b0);
    quiesce();
    apply_delim(CFG_DATA_W'(1), CHAR_BITS'(":"), '0, '0, '0, 1'b0);
    send_word(CHAR_BITS'("q"), 1'b1, 1'b1);
    quiesce();

    // ---- random part: several delimiter settings, long hold-off early on ----
    squeeze = 1'b1;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       lv = MAX_DELIM_LEN;
        1:       lv = 1;
        2:       lv = 2;
        3:       lv = 3;
        default: lv = $urandom_range(0, 7);
      endcase
      apply_delim({(CFG_DATA_W - DLEN_W)'($urandom), DLEN_W'(lv)},
                  pick_delim_char(), pick_delim_char(), pick_delim_char(), pick_delim_char(),
                  $urandom_range(0, 2) == 0);
      while (sent < (ph + 1) * RANDOM_ITEMS / PHASES) send_line(sent);
      quiesce();
    end

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
